// ===== sv/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// LC-3 execute package
// Shared types and opcode constants for the LC-3 execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package lc3_pkg;
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_EXEC = 2'd1;
	localparam logic [1:0] ACT_SETPC = 2'd2;

	localparam logic [3:0] OP_BR = 4'h0;
	localparam logic [3:0] OP_ADD = 4'h1;
	localparam logic [3:0] OP_LD = 4'h2;
	localparam logic [3:0] OP_ST = 4'h3;
	localparam logic [3:0] OP_JSR = 4'h4;
	localparam logic [3:0] OP_AND = 4'h5;
	localparam logic [3:0] OP_LDR = 4'h6;
	localparam logic [3:0] OP_STR = 4'h7;
	localparam logic [3:0] OP_NOT = 4'h9;
	localparam logic [3:0] OP_LDI = 4'hA;
	localparam logic [3:0] OP_STI = 4'hB;
	localparam logic [3:0] OP_JMP = 4'hC;
	localparam logic [3:0] OP_LEA = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_IND,
		ST_FINISH,
		ST_OUT
	} state_t;

	// Memory address source selected by the controller
	typedef enum logic [1:0] {
		MA_INPUT,
		MA_PC,
		MA_EA,
		MA_RDATA
	} maddr_sel_t;

	typedef struct packed {
		logic       take_input;  // latch input transaction
		logic       mem_we;
		logic       mem_we_store; // store instruction writes memory
		maddr_sel_t maddr_sel;
		logic       latch_ir;    // IR <= rdata, PC++
		logic       latch_ptr;   // pointer or load data <= rdata
		logic       finish;      // commit instruction results
		logic       simple;      // commit load / set pc / unused
		logic       out_load;    // load output register
	} ctrl_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] opcode;
	} stat_t;

	typedef struct packed {
		logic [15:0] pc_now;
		logic [2:0]  cond_flags;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_address;
		logic [15:0] mem_data;
		logic        trap_seen;
		logic [7:0]  trap_vector;
		logic        unsupported;
	} result_t;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'd0) return 3'd2;
		if (v[15]) return 3'd4;
		return 3'd1;
	endfunction
endpackage
`default_nettype wire

// ===== sv/lc3_instruction_execute_top.sv =====
// ----------------------------------------------------------------------------
// LC-3 instruction execute top
// Sixteen-bit LC-3 core stepped one transaction at a time.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)
// s_axis  | in  | action[1:0], address[17:2], data[33:18]
// m_axis  | out | pc_now, cond_flags, reg_written, reg_index, reg_value,
//         |     | mem_written, mem_address, mem_data, trap_seen, trap_vector,
//         |     | unsupported (82 bits, padded to 88)
// Load and set-PC go from fetch straight to output; execute steps through fetch read, data read,
// indirect read and commit, each memory read through the registered RAM port.
// Reset clears registers, PC and flags; memory holds no reset value.
// A stalled output holds the controller in its output state.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_instruction_execute_top
	import lc3_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,  // action, address, data
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [87:0]       m_tdata   // result fields, see table
);
	ctrl_t   ctrl;
	stat_t   stat;
	result_t res;
	logic    m_valid_q;

	wire out_free = !m_valid_q || m_tready;

	lc3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.out_free(out_free), .stat(stat), .ctrl(ctrl)
	);

	lc3_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(s_tdata[33:0]), .ctrl(ctrl),
		.stat(stat), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'd0, res.unsupported, res.trap_vector, res.trap_seen,
		res.mem_data, res.mem_address, res.mem_written, res.reg_value,
		res.reg_index, res.reg_written, res.cond_flags, res.pc_now};

	a_one_hot_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.take_input, ctrl.latch_ir, ctrl.latch_ptr, ctrl.finish,
			ctrl.simple, ctrl.out_load}))
		else $error("controller issued two commands at once");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |=> m_tvalid)
		else $error("result lost");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.latch_ir |-> !s_tready)
		else $error("input taken during execute");
endmodule
`default_nettype wire

// ===== sv/lc3_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single port write, single port registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/lc3_ctrl.sv =====
// ----------------------------------------------------------------------------
// LC-3 controller
// Sequences fetch, decode, indirect read and commit for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_ctrl
	import lc3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire logic  out_free,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		ctrl.maddr_sel = MA_PC;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.take_input = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				// load action writes here; exec issues the fetch read
				if (stat.action == ACT_EXEC) begin
					ctrl.maddr_sel = MA_PC;
					state_d = ST_DECODE;
				end else begin
					ctrl.maddr_sel = MA_INPUT;
					ctrl.mem_we = (stat.action == ACT_LOAD);
					ctrl.simple = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_DECODE: begin
				ctrl.latch_ir = 1'b1;
				ctrl.maddr_sel = MA_EA;  // first data read, EA from fresh IR
				state_d = ST_IND;
			end
			ST_IND: begin
				ctrl.latch_ptr = 1'b1;
				ctrl.maddr_sel = MA_RDATA;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				ctrl.maddr_sel = (stat.opcode == OP_STI) ? MA_RDATA : MA_EA;
				ctrl.mem_we_store = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/lc3_dp.sv =====
// ----------------------------------------------------------------------------
// LC-3 datapath
// Register file, PC, flags, memory and result formation.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_dp
	import lc3_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [33:0] in_data,
	input  wire ctrl_t       ctrl,
	output stat_t            stat,
	output result_t          res
);
	logic [1:0]  action_q;
	logic [15:0] addr_q, data_q;
	logic [15:0] gr_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic [15:0] ir_q, ptr_q;
	logic [15:0] rdata;
	logic [15:0] ea_base, ea_off, ea;
	logic [15:0] sr1v, opnd2, off9, off6, off11;
	logic [3:0]  op;
	logic [2:0]  dr, sr1;
	logic [ADDR_BITS-1:0] raddr, waddr;
	logic [15:0] wdata;
	logic        we, is_store;
	logic [15:0] pc1;

	assign stat.action = action_q;
	assign stat.opcode = op;

	// In decode the IR is still arriving on rdata
	wire [15:0] ir = ctrl.latch_ir ? rdata : ir_q;
	assign op = ir[15:12];
	assign dr = ir[11:9];
	assign sr1 = ir[8:6];
	assign off9 = {{7{ir[8]}}, ir[8:0]};
	assign off6 = {{10{ir[5]}}, ir[5:0]};
	assign off11 = {{5{ir[10]}}, ir[10:0]};
	assign sr1v = gr_q[sr1];
	assign opnd2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gr_q[ir[2:0]];
	// PC is already incremented once IR is latched
	assign pc1 = ctrl.latch_ir ? pc_q + 16'd1 : pc_q;
	assign ea_base = (op == OP_LDR || op == OP_STR) ? sr1v : pc1;
	assign ea_off = (op == OP_LDR || op == OP_STR) ? off6 : off9;
	assign ea = ea_base + ea_off;

	assign is_store = (op == OP_ST) || (op == OP_STI) || (op == OP_STR);

	always_comb begin
		case (ctrl.maddr_sel)
			MA_INPUT: raddr = addr_q[ADDR_BITS-1:0];
			MA_PC:    raddr = pc_q[ADDR_BITS-1:0];
			MA_EA:    raddr = ea[ADDR_BITS-1:0];
			// the pointer is still on rdata while it is being latched
			MA_RDATA: raddr = ctrl.latch_ptr ? rdata[ADDR_BITS-1:0] : ptr_q[ADDR_BITS-1:0];
			default:  raddr = pc_q[ADDR_BITS-1:0];
		endcase
	end
	assign waddr = raddr;
	assign we = ctrl.mem_we || (ctrl.mem_we_store && is_store);
	assign wdata = ctrl.mem_we ? data_q : gr_q[dr];

	lc3_ram #(.WIDTH(16), .DEPTH(1 << ADDR_BITS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	result_t r;
	always_comb begin
		r = '0;
		r.pc_now = pc_q;
		r.cond_flags = cc_q;
		case (op)
			OP_BR: if ((dr & cc_q) != 3'd0) r.pc_now = pc_q + off9;
			OP_ADD: begin r.reg_written = 1'b1; r.reg_value = sr1v + opnd2; end
			OP_AND: begin r.reg_written = 1'b1; r.reg_value = sr1v & opnd2; end
			OP_NOT: begin r.reg_written = 1'b1; r.reg_value = ~sr1v; end
			OP_LD, OP_LDR: begin r.reg_written = 1'b1; r.reg_value = ptr_q; end
			OP_LDI: begin r.reg_written = 1'b1; r.reg_value = rdata; end
			OP_LEA: begin r.reg_written = 1'b1; r.reg_value = ea; end
			OP_ST, OP_STR, OP_STI: begin
				r.mem_written = 1'b1;
				r.mem_address = 16'(raddr);
				r.mem_data = gr_q[dr];
			end
			OP_JMP: r.pc_now = sr1v;
			OP_JSR: begin
				r.reg_written = 1'b1;
				r.reg_value = pc_q;
				r.pc_now = ir[11] ? pc_q + off11 : sr1v;
			end
			OP_TRAP: begin r.trap_seen = 1'b1; r.trap_vector = ir[7:0]; end
			default: r.unsupported = 1'b1;
		endcase
		if (r.reg_written) begin
			r.reg_index = (op == OP_JSR) ? 3'd7 : dr;
			if (op != OP_JSR) r.cond_flags = flags_of(r.reg_value);
		end
	end

	// result of a load, set-PC or unused transaction
	result_t simp;
	always_comb begin
		simp = '0;
		simp.pc_now = (action_q == ACT_SETPC) ? addr_q : pc_q;
		simp.cond_flags = cc_q;
	end

	result_t pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			cc_q <= '0;
			for (int i = 0; i < 8; i++) gr_q[i] <= '0;
		end else begin
			if (ctrl.simple && action_q == ACT_SETPC) pc_q <= addr_q;
			if (ctrl.latch_ir) pc_q <= pc_q + 16'd1;
			if (ctrl.finish) begin
				pc_q <= r.pc_now;
				cc_q <= r.cond_flags;
				if (r.reg_written) gr_q[r.reg_index] <= r.reg_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take_input) begin
			action_q <= in_data[1:0];
			addr_q <= in_data[17:2];
			data_q <= in_data[33:18];
		end
		if (ctrl.latch_ir) ir_q <= rdata;
		if (ctrl.latch_ptr) ptr_q <= rdata;
		if (ctrl.finish) begin
			pend_q <= r;
		end else if (ctrl.simple) begin
			pend_q <= simp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) res <= pend_q;
	end
endmodule
`default_nettype wire

// ===== verif/lc3_instruction_execute_top_test.sv =====
// ----------------------------------------------------------------------------
// LC-3 instruction execute testbench
// Checks every result transaction of the LC-3 core against a behavioral
// predictor of the register file, PC, flags and memory image. A directed
// table opens the run; random programs of random instructions follow. Every
// memory word whose value an instruction uses is loaded before the core reads it.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_instruction_execute_top_test;
	import lc3_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS = 1400;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;

	lc3_instruction_execute_top #(.ADDR_BITS(16)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// core image kept by the predictor
	logic [15:0] gpr [8];
	logic [15:0] pc_img;
	logic [2:0] cc_img;
	logic [15:0] mem_img [bit [15:0]];

	result_t expected_q [$];
	int n_sent, n_checked, n_exec, errors, phase;
	int op_count [16];
	int hold_left;
	bit hold_done;

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic [15:0] r;
		r = v;
		for (int i = bits; i < 16; i++) r[i] = v[bits-1];
		return r;
	endfunction

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v == 16'd0) return 3'd2;
		if (v[15]) return 3'd4;
		return 3'd1;
	endfunction

	// advances the image by one transaction and returns the result it causes
	function automatic result_t step_core(input logic [1:0] act, input logic [15:0] addr,
			input logic [15:0] data);
		result_t r;
		logic [15:0] ir, off9, off6, opnd2, ret;
		logic [3:0] op;
		logic [2:0] dr, sr1;
		r = '0;
		if (act == ACT_LOAD) begin
			mem_img[addr] = data;
		end else if (act == ACT_SETPC) begin
			pc_img = addr;
		end else if (act == ACT_EXEC) begin
			ir = mem_img[pc_img];
			op = ir[15:12];
			dr = ir[11:9];
			sr1 = ir[8:6];
			off9 = sext(ir, 9);
			off6 = sext(ir, 6);
			opnd2 = ir[5] ? sext(ir, 5) : gpr[ir[2:0]];
			pc_img = pc_img + 16'd1;
			op_count[op]++;
			n_exec++;
			case (op)
				OP_BR: if ((dr & cc_img) != 3'd0) pc_img = pc_img + off9;
				OP_ADD: begin
					r.reg_written = 1'b1; r.reg_index = dr; r.reg_value = gpr[sr1] + opnd2;
				end
				OP_AND: begin
					r.reg_written = 1'b1; r.reg_index = dr; r.reg_value = gpr[sr1] & opnd2;
				end
				OP_NOT: begin r.reg_written = 1'b1; r.reg_index = dr; r.reg_value = ~gpr[sr1]; end
				OP_LD: begin
					r.reg_written = 1'b1; r.reg_index = dr; r.reg_value = mem_img[pc_img + off9];
				end
				OP_LDI: begin
					r.reg_written = 1'b1; r.reg_index = dr;
					r.reg_value = mem_img[mem_img[pc_img + off9]];
				end
				OP_LDR: begin
					r.reg_written = 1'b1; r.reg_index = dr;
					r.reg_value = mem_img[gpr[sr1] + off6];
				end
				OP_LEA: begin
					r.reg_written = 1'b1; r.reg_index = dr; r.reg_value = pc_img + off9;
				end
				OP_ST: begin
					r.mem_written = 1'b1; r.mem_address = pc_img + off9; r.mem_data = gpr[dr];
				end
				OP_STI: begin
					r.mem_written = 1'b1; r.mem_address = mem_img[pc_img + off9];
					r.mem_data = gpr[dr];
				end
				OP_STR: begin
					r.mem_written = 1'b1; r.mem_address = gpr[sr1] + off6; r.mem_data = gpr[dr];
				end
				OP_JMP: pc_img = gpr[sr1];
				OP_JSR: begin
					ret = pc_img;
					// JSRR reads its base before R7 takes the return address
					pc_img = ir[11] ? pc_img + sext(ir, 11) : gpr[sr1];
					gpr[7] = ret;
					r.reg_written = 1'b1; r.reg_index = 3'd7; r.reg_value = ret;
				end
				OP_TRAP: begin r.trap_seen = 1'b1; r.trap_vector = ir[7:0]; end
				default: r.unsupported = 1'b1;
			endcase
			if (r.reg_written && op != OP_JSR) begin
				gpr[r.reg_index] = r.reg_value;
				cc_img = cc_of(r.reg_value);
			end
			if (r.mem_written) mem_img[r.mem_address] = r.mem_data;
		end
		r.pc_now = pc_img;
		r.cond_flags = cc_img;
		return r;
	endfunction

	// sends one transaction; the block's results queue up in transaction order
	task automatic send(input logic [1:0] act, input logic [15:0] addr, input logic [15:0] data,
			input bit fixed = 0, input result_t fixed_res = '0);
		result_t r;
		bit ok;
		int idle_pct;
		r = step_core(act, addr, data);
		expected_q.push_back(fixed ? fixed_res : r);
		idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, data, addr, act};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		n_sent++;
		phase = (n_sent < N_ITEMS / 3) ? 0 : (n_sent < 2 * N_ITEMS / 3) ? 1 : 2;
	endtask

	task automatic make_present(input logic [15:0] a);
		if (!mem_img.exists(a)) send(ACT_LOAD, a, 16'($urandom));
	endtask

	// loads the instruction word and any word whose value it will use, then executes it
	task automatic exec_one();
		logic [15:0] ir, npc;
		if (!mem_img.exists(pc_img)) send(ACT_LOAD, pc_img, 16'($urandom));
		ir = mem_img[pc_img];
		npc = pc_img + 16'd1;
		case (ir[15:12])
			OP_LD, OP_STI: make_present(npc + sext(ir, 9));
			OP_LDI: begin
				make_present(npc + sext(ir, 9));
				make_present(mem_img[npc + sext(ir, 9)]);
			end
			OP_LDR: make_present(gpr[ir[8:6]] + sext(ir, 6));
			default: ;
		endcase
		send(ACT_EXEC, 16'($urandom), 16'($urandom));
	endtask

	typedef struct {
		logic [1:0] act;
		logic [15:0] addr;
		logic [15:0] data;
		bit fixed;
		logic [15:0] pc;
	} row_t;

	row_t dir_rows [$] = '{
		'{ACT_LOAD, 16'h0000, 16'h1020, 1, 16'h0000},   // ADD R0,R0,#0
		'{ACT_SETPC, 16'hFFFF, 16'h0000, 1, 16'hFFFF},
		'{ACT_LOAD, 16'hFFFF, 16'h0E02, 1, 16'hFFFF},   // BRnzp with no flag yet
		'{ACT_LOAD, 16'h0001, 16'h127F, 0, 16'h0},      // ADD R1,R1,#-1
		'{ACT_LOAD, 16'h0002, 16'h927F, 0, 16'h0},      // NOT R1,R1
		'{ACT_LOAD, 16'h0003, 16'h5270, 0, 16'h0},      // AND R1,R1,#-16
		'{ACT_LOAD, 16'h0004, 16'hE4FF, 0, 16'h0},      // LEA R2,#255
		'{ACT_LOAD, 16'h0005, 16'hF0FF, 0, 16'h0},      // TRAP xFF
		'{ACT_LOAD, 16'h0006, 16'h8000, 0, 16'h0},      // RTI
		'{ACT_LOAD, 16'h0007, 16'hD000, 0, 16'h0},      // reserved
		'{ACT_LOAD, 16'h0008, 16'h3500, 0, 16'h0},      // ST R2,#-256, wraps
		'{ACT_LOAD, 16'h0009, 16'h4C00, 0, 16'h0},      // JSR #-1024
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'hFFFF, 16'hFFFF, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_UNUSED, 16'hFFFF, 16'hFFFF, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0},
		'{ACT_EXEC, 16'h0000, 16'h0000, 0, 16'h0}
	};

	function automatic result_t unpack_result(input logic [87:0] d);
		result_t r;
		r.pc_now = d[15:0];
		r.cond_flags = d[18:16];
		r.reg_written = d[19];
		r.reg_index = d[22:20];
		r.reg_value = d[38:23];
		r.mem_written = d[39];
		r.mem_address = d[55:40];
		r.mem_data = d[71:56];
		r.trap_seen = d[72];
		r.trap_vector = d[80:73];
		r.unsupported = d[81];
		return r;
	endfunction

	task automatic compare_result(input result_t e, input result_t g);
		if (g.pc_now !== e.pc_now) begin
			$error("pc_now exp %h got %h", e.pc_now, g.pc_now); errors++;
		end
		if (g.cond_flags !== e.cond_flags) begin
			$error("cond_flags exp %h got %h", e.cond_flags, g.cond_flags); errors++;
		end
		if (g.reg_written !== e.reg_written) begin
			$error("reg_written exp %h got %h", e.reg_written, g.reg_written); errors++;
		end
		if (g.reg_index !== e.reg_index) begin
			$error("reg_index exp %h got %h", e.reg_index, g.reg_index); errors++;
		end
		if (g.reg_value !== e.reg_value) begin
			$error("reg_value exp %h got %h", e.reg_value, g.reg_value); errors++;
		end
		if (g.mem_written !== e.mem_written) begin
			$error("mem_written exp %h got %h", e.mem_written, g.mem_written); errors++;
		end
		if (g.mem_address !== e.mem_address) begin
			$error("mem_address exp %h got %h", e.mem_address, g.mem_address); errors++;
		end
		if (g.mem_data !== e.mem_data) begin
			$error("mem_data exp %h got %h", e.mem_data, g.mem_data); errors++;
		end
		if (g.trap_seen !== e.trap_seen) begin
			$error("trap_seen exp %h got %h", e.trap_seen, g.trap_seen); errors++;
		end
		if (g.trap_vector !== e.trap_vector) begin
			$error("trap_vector exp %h got %h", e.trap_vector, g.trap_vector); errors++;
		end
		if (g.unsupported !== e.unsupported) begin
			$error("unsupported exp %h got %h", e.unsupported, g.unsupported); errors++;
		end
	endtask

	// handshake signals change only at the rising edge, so the falling edge
	// sees exactly what the next rising edge will accept
	int quiet_cycles = 0;
	always @(negedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				compare_result(expected_q.pop_front(), unpack_result(m_tdata));
			end
			n_checked++;
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !arst_n) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (phase == 1 && !hold_done) begin
			// long hold-off so the core backs up into its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= ((phase == 0) ? 52 : (phase == 1) ? 33 : 0));
		end
	end

	initial begin
		result_t fr;
		int k;
		for (int i = 0; i < 8; i++) gpr[i] = '0;
		pc_img = '0;
		cc_img = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			fr = '0;
			fr.pc_now = dir_rows[i].pc;
			send(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].fixed, fr);
		end

		while (n_sent < N_ITEMS) begin
			k = $urandom_range(0, 99);
			if (k < 80) begin
				// program: jump somewhere, half the time into a small reused window
				send(ACT_SETPC, ($urandom_range(0, 1) ? 16'($urandom_range(0, 63))
					: 16'($urandom)), 16'($urandom));
				repeat ($urandom_range(1, 10)) exec_one();
			end else if (k < 90) begin
				send(ACT_LOAD, 16'($urandom), 16'($urandom));
			end else if (k < 95) begin
				send(ACT_UNUSED, 16'($urandom), 16'($urandom));
			end else begin
				send(ACT_SETPC, 16'($urandom), 16'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results, executed %0d instructions",
			n_sent, n_checked, n_exec);
		$display("Opcode counts: %p", op_count);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
